// ----- rtl/first_fit_heap_allocator_macros.svh -----
// Assertion macros shared by the checker file
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, off while reset is low
`define FFHA_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ffha assertion failed");

// Next-cycle implication, off while reset is low
`define FFHA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ffha assertion failed");

`endif

// ----- rtl/ffha_pkg.sv -----
package ffha_pkg;

  // Default sizing of the heap
  localparam int unsigned DEF_HEAP_BYTES       = 65536;
  localparam int unsigned DEF_HEADER_BYTES     = 32;
  localparam int unsigned DEF_SPLIT_TAIL_BYTES = 32;

  // Fixed port widths
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned OUT_SIZE_W = 17;

  // Rounded request and split threshold widths
  localparam int unsigned REQ_W  = 34;
  localparam int unsigned NEED_W = 35;

  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_NONE    = 3'd1,
    ST_OOM     = 3'd2,
    ST_CORRUPT = 3'd3,
    ST_DOUBLE  = 3'd4,
    ST_BADINIT = 3'd5
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLR,
    S_INIT_CHK,
    S_INIT_WR,
    S_AL_PREP,
    S_AL_NEED,
    S_AL_RD,
    S_AL_CHK,
    S_AL_SPLIT,
    S_AL_FIN,
    S_FR_A,
    S_FR_B,
    S_FR_C,
    S_FR_SR,
    S_FR_SC,
    S_FR_PR,
    S_FR_PC,
    S_FR_MG,
    S_FR_CL
  } state_e;

endpackage

// ----- rtl/first_fit_heap_allocator.sv -----
// First-fit heap allocator with block splitting and neighbour coalescing.
// Command channel: drive opcode_i, address_i and request_size_i with start_i;
// the request transfers at a clock edge where start_i is high and busy_o is
// low. Each request yields one result: status_o, result_address_o,
// granted_size_o and used_bytes_o are shown for exactly one cycle while
// done_o is high. The receiver cannot stall; it must take the result then.
// Block headers live in a single-port-write, registered-read table, one
// entry per 8-byte granule. Init sweeps the table clear, one granule a
// cycle, then lays down one free block. Alloc walks the block headers in
// first-fit order and writes one more header when the chosen block is split.
// Free absorbs free successors, then walks the blocks ahead of it from the
// origin to find a free predecessor to merge with. Opcode three and early
// errors give their result without a walk.
// busy_o drops in the result cycle, so the next request can transfer there.
// After reset the block holds busy_o high while it clears every start mark,
// then the heap reads as not initialised.
module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int unsigned HEAP_BYTES       = DEF_HEAP_BYTES,
  parameter int unsigned HEADER_BYTES     = DEF_HEADER_BYTES,
  parameter int unsigned SPLIT_TAIL_BYTES = DEF_SPLIT_TAIL_BYTES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [OP_W-1:0]       opcode_i,
  input  logic [31:0]           address_i,
  input  logic [31:0]           request_size_i,
  output logic                  done_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic [31:0]           result_address_o,
  output logic [OUT_SIZE_W-1:0] granted_size_o,
  output logic [OUT_SIZE_W-1:0] used_bytes_o
);

  localparam int unsigned HDR_SPAN = ((HEADER_BYTES + 7) / 8) * 8;
  localparam int unsigned GRANULES = (HEAP_BYTES + 7) / 8;
  localparam int unsigned GW       = $clog2(GRANULES);
  localparam int unsigned SZW      = $clog2(HEAP_BYTES + 1);
  localparam int unsigned OW       = SZW + 1;
  localparam int unsigned EW       = SZW + 2;

  localparam logic [OW-1:0]     HDR_OFF  = OW'(HDR_SPAN);
  localparam logic [SZW-1:0]    HDR_SZ   = SZW'(HDR_SPAN);
  localparam logic [NEED_W-1:0] SPLIT_AD = NEED_W'(HDR_SPAN + SPLIT_TAIL_BYTES);
  localparam logic [31:0]       INIT_MIN = 32'(HDR_SPAN + 8);
  localparam logic [31:0]       INIT_MAX = 32'(HEAP_BYTES);

  // Control state
  state_e           state_q, state_d;
  logic             ready_q, ready_d;
  logic [OW-1:0]    len_q, len_d;
  logic [SZW-1:0]   bytes_q, bytes_d;
  logic [GW-1:0]    cnt_q, cnt_d;
  logic [GW-1:0]    clr_last_q, clr_last_d;
  logic             init_clr_q, init_clr_d;
  logic             done_q;
  status_e          status_q;
  logic [31:0]      raddr_out_q;
  logic [SZW-1:0]   granted_q;
  logic [SZW-1:0]   used_q;

  // Working payload
  logic [31:0]      origin_q, origin_d;
  logic [31:0]      addr_q, addr_d;
  logic [31:0]      size_q, size_d;
  logic [31:0]      offw_q, offw_d;
  logic [OW-1:0]    off_q, off_d;
  logic [REQ_W-1:0] req_q, req_d;
  logic [NEED_W-1:0] need_q, need_d;
  logic [SZW-1:0]   sz_q, sz_d;
  logic [SZW-1:0]   grant_q, grant_d;
  logic [OW-1:0]    nxt_q, nxt_d;
  logic [OW-1:0]    p_q, p_d;
  logic [OW-1:0]    prev_q, prev_d;
  logic [SZW-1:0]   prev_sz_q, prev_sz_d;
  logic             prev_used_q, prev_used_d;
  logic             have_prev_q, have_prev_d;

  // Result of this cycle
  logic             emit;
  status_e          emit_status;
  logic [31:0]      emit_addr;
  logic [SZW-1:0]   emit_grant;
  logic [SZW-1:0]   emit_used;

  // Table port
  logic             ram_we;
  logic [GW-1:0]    ram_waddr;
  logic [EW-1:0]    ram_wdata;
  logic [GW-1:0]    ram_raddr;
  logic [EW-1:0]    ram_rdata;

  // Shared arithmetic
  logic             rd_start;
  logic             rd_used;
  logic [SZW-1:0]   rd_size;
  logic [NEED_W-1:0] rd_size_n;
  logic [31:0]      init_len;
  logic [32:0]      init_end;
  logic [REQ_W-1:0] req_round;
  logic [32:0]      free_base;
  logic [31:0]      free_off;
  logic [OW-1:0]    walk_off;
  logic [OW-1:0]    split_off;

  ffha_ram #(
    .WIDTH (EW),
    .DEPTH (GRANULES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_start  = ram_rdata[EW-1];
  assign rd_used   = ram_rdata[EW-2];
  assign rd_size   = ram_rdata[SZW-1:0];
  assign rd_size_n = NEED_W'(rd_size);
  assign init_len  = {size_q[31:3], 3'b000};
  assign init_end  = {1'b0, addr_q} + {1'b0, init_len};
  assign req_round = ({2'b00, size_q} + REQ_W'(7)) & ~REQ_W'(7);
  assign free_base = {1'b0, origin_q} + 33'(HDR_SPAN);
  assign free_off  = addr_q - origin_q - 32'(HDR_SPAN);
  assign split_off = off_q + HDR_OFF + OW'(grant_q);

  // One adder shared by the walks: step past the header and payload
  always_comb begin
    case (state_q)
      S_FR_SC: walk_off = nxt_q + HDR_OFF + OW'(rd_size);
      S_FR_PC: walk_off = p_q + HDR_OFF + OW'(rd_size);
      default: walk_off = off_q + HDR_OFF + OW'(rd_size);
    endcase
  end

  // Sequencer: next state, table access and result
  always_comb begin
    state_d     = state_q;
    ready_d     = ready_q;
    len_d       = len_q;
    bytes_d     = bytes_q;
    cnt_d       = cnt_q;
    clr_last_d  = clr_last_q;
    init_clr_d  = init_clr_q;
    origin_d    = origin_q;
    addr_d      = addr_q;
    size_d      = size_q;
    offw_d      = offw_q;
    off_d       = off_q;
    req_d       = req_q;
    need_d      = need_q;
    sz_d        = sz_q;
    grant_d     = grant_q;
    nxt_d       = nxt_q;
    p_d         = p_q;
    prev_d      = prev_q;
    prev_sz_d   = prev_sz_q;
    prev_used_d = prev_used_q;
    have_prev_d = have_prev_q;
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_addr   = '0;
    emit_grant  = '0;
    emit_used   = bytes_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_raddr   = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          addr_d = address_i;
          size_d = request_size_i;
          case (opcode_e'(opcode_i))
            OP_INIT:  state_d = S_INIT_CHK;
            OP_ALLOC: state_d = S_AL_PREP;
            OP_FREE:  state_d = S_FR_A;
            default: begin
              emit        = 1'b1;
              emit_status = ST_NONE;
            end
          endcase
        end
      end

      // Sweep the table clear, one granule a cycle
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        if (cnt_q == clr_last_q) begin
          state_d = init_clr_q ? S_INIT_WR : S_IDLE;
        end else begin
          cnt_d = cnt_q + GW'(1);
        end
      end

      S_INIT_CHK: begin
        if (addr_q[2:0] != 3'b000 || init_len < INIT_MIN || init_len > INIT_MAX ||
            init_end > 33'h1_0000_0000) begin
          emit        = 1'b1;
          emit_status = ST_BADINIT;
          state_d     = S_IDLE;
        end else begin
          origin_d   = addr_q;
          len_d      = init_len[OW-1:0];
          bytes_d    = '0;
          ready_d    = 1'b1;
          cnt_d      = '0;
          clr_last_d = GW'((init_len >> 3) - 32'd1);
          init_clr_d = 1'b1;
          state_d    = S_CLR;
        end
      end

      // Lay down the single free block
      S_INIT_WR: begin
        ram_we      = 1'b1;
        ram_waddr   = '0;
        ram_wdata   = {1'b1, 1'b0, SZW'(len_q - HDR_OFF)};
        init_clr_d  = 1'b0;
        emit        = 1'b1;
        emit_grant  = SZW'(len_q - HDR_OFF);
        emit_used   = '0;
        state_d     = S_IDLE;
      end

      S_AL_PREP: begin
        if (size_q == '0) begin
          emit        = 1'b1;
          emit_status = ST_NONE;
          state_d     = S_IDLE;
        end else if (!ready_q) begin
          emit        = 1'b1;
          emit_status = ST_OOM;
          state_d     = S_IDLE;
        end else begin
          req_d   = req_round;
          off_d   = '0;
          state_d = S_AL_NEED;
        end
      end

      S_AL_NEED: begin
        need_d  = {1'b0, req_q} + SPLIT_AD;
        state_d = S_AL_RD;
      end

      // Fetch the header at the walk position
      S_AL_RD: begin
        if (off_q < len_q) begin
          ram_raddr = off_q[GW+2:3];
          state_d   = S_AL_CHK;
        end else begin
          emit        = 1'b1;
          emit_status = ST_OOM;
          state_d     = S_IDLE;
        end
      end

      S_AL_CHK: begin
        if (!rd_start) begin
          emit        = 1'b1;
          emit_status = ST_OOM;
          state_d     = S_IDLE;
        end else if (!rd_used && rd_size_n >= {1'b0, req_q}) begin
          sz_d = rd_size;
          if (rd_size_n >= need_q) begin
            grant_d = req_q[SZW-1:0];
            state_d = S_AL_SPLIT;
          end else begin
            grant_d = rd_size;
            state_d = S_AL_FIN;
          end
        end else begin
          off_d   = walk_off;
          state_d = S_AL_RD;
        end
      end

      // Carve the tail off as a new free block
      S_AL_SPLIT: begin
        ram_we    = 1'b1;
        ram_waddr = split_off[GW+2:3];
        ram_wdata = {1'b1, 1'b0, sz_q - grant_q - HDR_SZ};
        state_d   = S_AL_FIN;
      end

      S_AL_FIN: begin
        ram_we     = 1'b1;
        ram_waddr  = off_q[GW+2:3];
        ram_wdata  = {1'b1, 1'b1, grant_q};
        bytes_d    = bytes_q + grant_q;
        emit       = 1'b1;
        emit_addr  = origin_q + 32'(off_q) + 32'(HDR_SPAN);
        emit_grant = grant_q;
        emit_used  = bytes_q + grant_q;
        state_d    = S_IDLE;
      end

      S_FR_A: begin
        if (addr_q == '0) begin
          emit        = 1'b1;
          emit_status = ST_NONE;
          state_d     = S_IDLE;
        end else if (!ready_q || {1'b0, addr_q} < free_base) begin
          emit        = 1'b1;
          emit_status = ST_CORRUPT;
          state_d     = S_IDLE;
        end else begin
          offw_d  = free_off;
          state_d = S_FR_B;
        end
      end

      S_FR_B: begin
        if (offw_q >= 32'(len_q) || offw_q[2:0] != 3'b000) begin
          emit        = 1'b1;
          emit_status = ST_CORRUPT;
          state_d     = S_IDLE;
        end else begin
          off_d     = offw_q[OW-1:0];
          ram_raddr = offw_q[GW+2:3];
          state_d   = S_FR_C;
        end
      end

      S_FR_C: begin
        if (!rd_start) begin
          emit        = 1'b1;
          emit_status = ST_CORRUPT;
          state_d     = S_IDLE;
        end else if (!rd_used) begin
          emit        = 1'b1;
          emit_status = ST_DOUBLE;
          state_d     = S_IDLE;
        end else begin
          sz_d        = rd_size;
          grant_d     = rd_size;
          nxt_d       = walk_off;
          p_d         = '0;
          have_prev_d = 1'b0;
          state_d     = S_FR_SR;
        end
      end

      // Absorb free successors
      S_FR_SR: begin
        if (nxt_q < len_q) begin
          ram_raddr = nxt_q[GW+2:3];
          state_d   = S_FR_SC;
        end else begin
          state_d = S_FR_PR;
        end
      end

      S_FR_SC: begin
        if (!rd_start || rd_used) begin
          state_d = S_FR_PR;
        end else begin
          sz_d      = sz_q + HDR_SZ + rd_size;
          ram_we    = 1'b1;
          ram_waddr = nxt_q[GW+2:3];
          nxt_d     = walk_off;
          state_d   = S_FR_SR;
        end
      end

      // Walk from the origin to find the predecessor
      S_FR_PR: begin
        if (p_q < off_q) begin
          ram_raddr = p_q[GW+2:3];
          state_d   = S_FR_PC;
        end else begin
          state_d = S_FR_MG;
        end
      end

      S_FR_PC: begin
        if (!rd_start) begin
          state_d = S_FR_MG;
        end else begin
          prev_d      = p_q;
          prev_sz_d   = rd_size;
          prev_used_d = rd_used;
          have_prev_d = 1'b1;
          p_d         = walk_off;
          state_d     = S_FR_PR;
        end
      end

      S_FR_MG: begin
        ram_we = 1'b1;
        if (have_prev_q && p_q == off_q && !prev_used_q) begin
          ram_waddr = prev_q[GW+2:3];
          ram_wdata = {1'b1, 1'b0, prev_sz_q + HDR_SZ + sz_q};
          state_d   = S_FR_CL;
        end else begin
          ram_waddr  = off_q[GW+2:3];
          ram_wdata  = {1'b1, 1'b0, sz_q};
          bytes_d    = (bytes_q >= grant_q) ? bytes_q - grant_q : '0;
          emit       = 1'b1;
          emit_grant = grant_q;
          emit_used  = (bytes_q >= grant_q) ? bytes_q - grant_q : '0;
          state_d    = S_IDLE;
        end
      end

      // Drop the merged block's own header
      S_FR_CL: begin
        ram_we     = 1'b1;
        ram_waddr  = off_q[GW+2:3];
        bytes_d    = (bytes_q >= grant_q) ? bytes_q - grant_q : '0;
        emit       = 1'b1;
        emit_grant = grant_q;
        emit_used  = (bytes_q >= grant_q) ? bytes_q - grant_q : '0;
        state_d    = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold control state and the result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      ready_q     <= 1'b0;
      len_q       <= '0;
      bytes_q     <= '0;
      cnt_q       <= '0;
      clr_last_q  <= GW'(GRANULES - 1);
      init_clr_q  <= 1'b0;
      origin_q    <= '0;
      done_q      <= 1'b0;
      status_q    <= ST_OK;
      raddr_out_q <= '0;
      granted_q   <= '0;
      used_q      <= '0;
    end else begin
      state_q    <= state_d;
      ready_q    <= ready_d;
      len_q      <= len_d;
      bytes_q    <= bytes_d;
      cnt_q      <= cnt_d;
      clr_last_q <= clr_last_d;
      init_clr_q <= init_clr_d;
      origin_q   <= origin_d;
      done_q     <= emit;
      if (emit) begin
        status_q    <= emit_status;
        raddr_out_q <= emit_addr;
        granted_q   <= emit_grant;
        used_q      <= emit_used;
      end
    end
  end

  // Advance the working payload
  always_ff @(posedge clk_i) begin
    addr_q      <= addr_d;
    size_q      <= size_d;
    offw_q      <= offw_d;
    off_q       <= off_d;
    req_q       <= req_d;
    need_q      <= need_d;
    sz_q        <= sz_d;
    grant_q     <= grant_d;
    nxt_q       <= nxt_d;
    p_q         <= p_d;
    prev_q      <= prev_d;
    prev_sz_q   <= prev_sz_d;
    prev_used_q <= prev_used_d;
    have_prev_q <= have_prev_d;
  end

  assign busy_o           = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign result_address_o = raddr_out_q;
  assign granted_size_o   = OUT_SIZE_W'(granted_q);
  assign used_bytes_o     = OUT_SIZE_W'(used_q);

endmodule

// ----- rtl/ffha_ram.sv -----
module ffha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one entry, read one entry through a register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/ffha_checker.sv -----
`include "first_fit_heap_allocator_macros.svh"

module ffha_checker
  import ffha_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start_i,
  input logic                  busy_o,
  input logic [OP_W-1:0]       opcode_i,
  input logic                  done_o,
  input logic [STATUS_W-1:0]   status_o,
  input logic [31:0]           result_address_o,
  input logic [OUT_SIZE_W-1:0] granted_size_o,
  input logic [OUT_SIZE_W-1:0] used_bytes_o
);

  // A real request keeps the block busy for at least the next cycle
  `FFHA_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o && (opcode_i == OP_INIT || opcode_i == OP_ALLOC || opcode_i == OP_FREE), busy_o)

  // No result without a transfer in flight
  `FFHA_ASSERT_NEXT(a_no_spurious, clk_i, rst_ni, !busy_o && !start_i, !done_o)

  // A failed request grants nothing
  `FFHA_ASSERT_IMPLY(a_err_empty, clk_i, rst_ni, done_o && status_o != ST_OK, result_address_o == '0 && granted_size_o == '0)

  // A failed request leaves the used count as it was
  `FFHA_ASSERT_IMPLY(a_err_used, clk_i, rst_ni, done_o && status_o != ST_OK, $stable(used_bytes_o))

  // A granted block is granule sized
  `FFHA_ASSERT_IMPLY(a_grant_gran, clk_i, rst_ni, done_o && status_o == ST_OK && result_address_o != '0, granted_size_o != '0 && granted_size_o[2:0] == 3'b000)

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);
